FILE: rtl/core/sclas_pkg.sv
`timescale 1ns / 1ps

package sclas_pkg;

  localparam int RING_DEPTH = 32;
  localparam int PTR_W = $clog2(RING_DEPTH);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_END   = 3'd2,
    KIND_READ  = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_LINE,
    CMD_READ
  } cmd_op_t;

  typedef enum logic [1:0] {
    PH_NAME,
    PH_SKIP,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO_CR,
    ST_ECHO_LF,
    ST_FETCH,
    ST_SCAN,
    ST_END,
    ST_RD_FETCH,
    ST_RD_EMIT
  } back_state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic signed [15:0] param_value;
    logic               pending;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

FILE: rtl/core/sclas_front.sv
`timescale 1ns / 1ps

module sclas_front (
  input  logic              push,
  output logic              full,
  input  sclas_pkg::in_item_t item,
  input  logic              cmdq_full,
  output logic              cmd_push,
  output sclas_pkg::cmd_t   cmd
);

  assign full     = cmdq_full;
  assign cmd_push = push && !cmdq_full;

  // Sort each transaction into a store, a line end or a read.
  always_comb begin
    cmd.data = item.rx_byte;
    if (item.op) begin
      cmd.op = sclas_pkg::CMD_READ;
    end else if (item.rx_byte == sclas_pkg::CH_CR || item.rx_byte == sclas_pkg::CH_LF) begin
      cmd.op = sclas_pkg::CMD_LINE;
    end else begin
      cmd.op = sclas_pkg::CMD_STORE;
    end
  end

endmodule

FILE: rtl/core/sclas_cmd_fifo.sv
`timescale 1ns / 1ps

module sclas_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  sclas_pkg::cmd_t wr_data,
  output logic            is_full,
  input  logic            rd_en,
  output sclas_pkg::cmd_t rd_data,
  output logic            is_empty
);

  sclas_pkg::cmd_t                   slots [sclas_pkg::CMDQ_DEPTH];
  logic [sclas_pkg::CMDQ_PTR_W-1:0]  wr_ptr;
  logic [sclas_pkg::CMDQ_PTR_W-1:0]  rd_ptr;
  logic [sclas_pkg::CMDQ_CNT_W-1:0]  count;
  logic                              do_wr;
  logic                              do_rd;

  assign is_full  = (count == sclas_pkg::CMDQ_CNT_W'(sclas_pkg::CMDQ_DEPTH));
  assign is_empty = (count == '0);
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && !is_empty;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == sclas_pkg::CMDQ_PTR_W'(sclas_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : wr_ptr + sclas_pkg::CMDQ_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == sclas_pkg::CMDQ_PTR_W'(sclas_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : rd_ptr + sclas_pkg::CMDQ_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + sclas_pkg::CMDQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - sclas_pkg::CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/sclas_back.sv
`timescale 1ns / 1ps

module sclas_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sclas_pkg::cmd_t      cmd,
  input  logic                 cmd_avail,
  output logic                 cmd_pop,
  output logic                 empty,
  input  logic                 pop,
  output sclas_pkg::out_item_t result
);

  logic [7:0] ring [sclas_pkg::RING_DEPTH];
  logic [7:0] rdata;

  sclas_pkg::back_state_t state, state_next;
  sclas_pkg::phase_t      phase, phase_next;
  sclas_pkg::ptr_t        wp, wp_next;
  sclas_pkg::ptr_t        rp, rp_next;
  logic [15:0]            acc, acc_next;
  logic                   neg, neg_next;

  logic                   out_valid;
  sclas_pkg::out_item_t   out_q;
  logic                   out_ready;
  logic                   emit;
  sclas_pkg::out_item_t   emit_item;

  logic                   mem_we;
  logic                   is_blank;
  logic                   is_digit;
  logic [15:0]            acc_step;
  sclas_pkg::ptr_t        wp_inc;
  sclas_pkg::ptr_t        rp_inc;

  assign out_ready = !out_valid || pop;
  assign empty     = !out_valid;
  assign result    = out_q;
  assign wp_inc    = sclas_pkg::ptr_inc(wp);
  assign rp_inc    = sclas_pkg::ptr_inc(rp);

  assign is_blank = (rdata == sclas_pkg::CH_SPACE) ||
                    (rdata >= sclas_pkg::CH_TAB && rdata <= sclas_pkg::CH_CR);
  assign is_digit = (rdata >= sclas_pkg::CH_ZERO) && (rdata <= sclas_pkg::CH_NINE);
  // acc * 10 + digit, wrapping at 16 bits.
  assign acc_step = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} +
                    {12'd0, rdata[3:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wp] <= cmd.data;
    end
    rdata <= ring[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sclas_pkg::ST_IDLE;
      phase     <= sclas_pkg::PH_NAME;
      wp        <= '0;
      rp        <= '0;
      acc       <= '0;
      neg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      wp    <= wp_next;
      rp    <= rp_next;
      acc   <= acc_next;
      neg   <= neg_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    wp_next    = wp;
    rp_next    = rp;
    acc_next   = acc;
    neg_next   = neg;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    emit_item  = '{kind: sclas_pkg::KIND_ECHO, data_byte: 8'd0, param_value: 16'sd0,
                   pending: 1'b0, last_of_run: 1'b0};

    case (state)
      sclas_pkg::ST_IDLE: begin
        if (cmd_avail && out_ready) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            sclas_pkg::CMD_STORE: begin
              // The ring holds text afterwards whether or not this byte fits.
              emit                  = 1'b1;
              emit_item.data_byte   = cmd.data;
              emit_item.pending     = 1'b1;
              emit_item.last_of_run = 1'b1;
              if (wp_inc != rp) begin
                mem_we  = 1'b1;
                wp_next = wp_inc;
              end
            end
            sclas_pkg::CMD_LINE: begin
              emit                = 1'b1;
              emit_item.data_byte = cmd.data;
              state_next          = sclas_pkg::ST_ECHO_CR;
            end
            default: begin
              if (wp == rp) begin
                emit                  = 1'b1;
                emit_item.kind        = sclas_pkg::KIND_EMPTY;
                emit_item.last_of_run = 1'b1;
              end else begin
                state_next = sclas_pkg::ST_RD_FETCH;
              end
            end
          endcase
        end
      end
      sclas_pkg::ST_ECHO_CR: begin
        if (out_ready) begin
          emit                = 1'b1;
          emit_item.data_byte = sclas_pkg::CH_CR;
          state_next          = sclas_pkg::ST_ECHO_LF;
        end
      end
      sclas_pkg::ST_ECHO_LF: begin
        if (out_ready) begin
          emit                  = 1'b1;
          emit_item.data_byte   = sclas_pkg::CH_LF;
          emit_item.last_of_run = (wp == rp);
          phase_next            = sclas_pkg::PH_NAME;
          acc_next              = '0;
          neg_next              = 1'b0;
          state_next            = (wp == rp) ? sclas_pkg::ST_IDLE : sclas_pkg::ST_FETCH;
        end
      end
      sclas_pkg::ST_FETCH: begin
        if (rp == wp || phase == sclas_pkg::PH_DONE) begin
          state_next = sclas_pkg::ST_END;
        end else begin
          state_next = sclas_pkg::ST_SCAN;
        end
      end
      sclas_pkg::ST_SCAN: begin
        case (phase)
          sclas_pkg::PH_NAME: begin
            if (rdata == sclas_pkg::CH_NUL) begin
              phase_next = sclas_pkg::PH_DONE;
              rp_next    = rp_inc;
              state_next = sclas_pkg::ST_FETCH;
            end else if (rdata == sclas_pkg::CH_SPACE) begin
              phase_next = sclas_pkg::PH_SKIP;
              rp_next    = rp_inc;
              state_next = sclas_pkg::ST_FETCH;
            end else if (out_ready) begin
              emit                = 1'b1;
              emit_item.kind      = sclas_pkg::KIND_NAME;
              emit_item.data_byte = rdata;
              rp_next             = rp_inc;
              state_next          = sclas_pkg::ST_FETCH;
            end
          end
          sclas_pkg::PH_SKIP: begin
            rp_next    = rp_inc;
            state_next = sclas_pkg::ST_FETCH;
            if (is_blank) begin
              phase_next = sclas_pkg::PH_SKIP;
            end else if (rdata == sclas_pkg::CH_PLUS || rdata == sclas_pkg::CH_MINUS) begin
              neg_next   = (rdata == sclas_pkg::CH_MINUS);
              phase_next = sclas_pkg::PH_DIGIT;
            end else if (is_digit) begin
              acc_next   = acc_step;
              phase_next = sclas_pkg::PH_DIGIT;
            end else begin
              phase_next = sclas_pkg::PH_DONE;
            end
          end
          default: begin
            rp_next    = rp_inc;
            state_next = sclas_pkg::ST_FETCH;
            if (is_digit) begin
              acc_next = acc_step;
            end else begin
              phase_next = sclas_pkg::PH_DONE;
            end
          end
        endcase
      end
      sclas_pkg::ST_END: begin
        if (out_ready) begin
          emit                  = 1'b1;
          emit_item.kind        = sclas_pkg::KIND_END;
          emit_item.param_value = neg ? -$signed(acc) : $signed(acc);
          emit_item.last_of_run = 1'b1;
          wp_next               = '0;
          rp_next               = '0;
          state_next            = sclas_pkg::ST_IDLE;
        end
      end
      sclas_pkg::ST_RD_FETCH: begin
        state_next = sclas_pkg::ST_RD_EMIT;
      end
      sclas_pkg::ST_RD_EMIT: begin
        if (out_ready) begin
          emit                  = 1'b1;
          emit_item.kind        = sclas_pkg::KIND_READ;
          emit_item.data_byte   = rdata;
          emit_item.pending     = (rp_inc != wp);
          emit_item.last_of_run = 1'b1;
          rp_next               = rp_inc;
          state_next            = sclas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sclas_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/serial_command_line_assembler.sv
`timescale 1ns / 1ps
// The first result of a transaction passes through the command queue and the output
// register before it reaches the result ports. The back end handles one command at a time
// while the command queue holds up to two more; a line end echoes its byte, then CR and LF,
// and if text is held, scans it one ring read per byte (FETCH, SCAN) before its end result.
// Reset is synchronous and active high; it empties both queues and zeroes the pointers,
// while the ring contents are left as they are.

module serial_command_line_assembler (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  sclas_pkg::in_item_t  item,
  input  logic                 pop,
  output logic                 empty,
  output sclas_pkg::out_item_t result
);

  logic            cmdq_full;
  logic            cmdq_empty;
  logic            cmd_push;
  logic            cmd_pop;
  sclas_pkg::cmd_t cmd_in;
  sclas_pkg::cmd_t cmd_out;

  sclas_front u_front (
    .push      (push),
    .full      (full),
    .item      (item),
    .cmdq_full (cmdq_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  sclas_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_push),
    .wr_data  (cmd_in),
    .is_full  (cmdq_full),
    .rd_en    (cmd_pop),
    .rd_data  (cmd_out),
    .is_empty (cmdq_empty)
  );

  sclas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_avail (!cmdq_empty),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

FILE: rtl/core/sclas_checker.sv
`timescale 1ns / 1ps

module sclas_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input sclas_pkg::in_item_t  item,
  input logic                 pop,
  input logic                 empty,
  input sclas_pkg::out_item_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == sclas_pkg::KIND_END) |->
      (result.data_byte == 8'd0 && !result.pending && result.last_of_run))
    else $error("bad command end transaction");

  a_param_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind != sclas_pkg::KIND_END) |-> (result.param_value == 16'sd0))
    else $error("parameter set outside command end");

  a_read_empty: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == sclas_pkg::KIND_EMPTY) |->
      (!result.pending && result.last_of_run && result.data_byte == 8'd0))
    else $error("bad read empty transaction");

endmodule

bind serial_command_line_assembler sclas_checker u_sclas_checker (.*);
